@@ sv/mzr_pkg.sv @@
// ----------------------------------------------------------------------------
// MZ header repacker package
// Shared types and constants for the header repacker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mzr_pkg;

    localparam int HdrLen = 28;
    localparam logic [15:0] MzSig = 16'h5A4D;

    localparam logic [4:0] IdxLlbLo = 5'd2;
    localparam logic [4:0] IdxLlbHi = 5'd3;
    localparam logic [4:0] IdxBlkLo = 5'd4;
    localparam logic [4:0] IdxBlkHi = 5'd5;
    localparam logic [4:0] IdxPgLo  = 5'd8;
    localparam logic [4:0] IdxPgHi  = 5'd9;
    localparam logic [4:0] IdxOffLo = 5'd24;
    localparam logic [4:0] IdxOffHi = 5'd25;

    typedef logic [7:0] t_hdr [HdrLen];

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_NOT_EXE = 2'd1,
        ST_SHORT   = 2'd2,
        ST_EARLY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_HDR,
        BODY_REL,
        BODY_DAT
    } t_body;

    typedef struct packed {
        t_body       body;
        logic [4:0]  blen;
        logic [31:0] word;
        logic        dat_last;
        logic [3:0]  pad;
        logic        sts;
        t_status     code;
        logic [5:0]  total;
    } t_job;

    typedef struct packed {
        logic [15:0] extra;
        logic [15:0] cnt;
        logic [19:0] drop;
        logic [3:0]  pad;
    } t_plan;

    typedef struct packed {
        logic [24:0] size;
        logic [15:0] npg;
        logic [4:0]  outlen;
    } t_hdr_new;

endpackage

`default_nettype wire

@@ sv/mzr_hdr_calc.sv @@
// ----------------------------------------------------------------------------
// MZ header field calculator
// Pipelined recomputation of the rewritten header fields from the store.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_hdr_calc (
    input  wire logic             i_clk,
    input  wire mzr_pkg::t_hdr    i_hdr,
    input  wire logic             i_sig_enable,
    output mzr_pkg::t_plan        o_plan,
    output mzr_pkg::t_hdr_new     o_new
);

    logic [15:0] llb, bc, cnt, pg, off;
    logic [4:0]  outlen;
    logic [17:0] rlen;
    logic [18:0] oldend, hsum;
    logic [19:0] pg16;
    mzr_pkg::t_plan plan;
    logic [15:0] npg;
    logic [24:0] base;

    mzr_pkg::t_plan r_plan;
    logic [15:0] r_npg;
    logic [4:0]  r_outlen;
    logic [24:0] r_base, r_t, r_d, r_size;

    always_comb begin
        llb    = {i_hdr[3], i_hdr[2]};
        bc     = {i_hdr[5], i_hdr[4]};
        cnt    = {i_hdr[7], i_hdr[6]};
        pg     = {i_hdr[9], i_hdr[8]};
        off    = {i_hdr[25], i_hdr[24]};
        outlen = i_sig_enable ? 5'd30 : 5'd28;
        rlen   = {cnt, 2'b00};
        oldend = 19'(off) + 19'(rlen);
        pg16   = {pg, 4'b0000};
        hsum   = 19'(rlen) + 19'(outlen);
        npg    = 16'((hsum + 19'd15) >> 4);
        plan.extra = (off > 16'd28) ? off - 16'd28 : 16'd0;
        plan.cnt   = cnt;
        plan.drop  = (pg16 > 20'(oldend)) ? pg16 - 20'(oldend) : 20'd0;
        plan.pad   = 4'd0 - hsum[3:0];
        base = 25'({bc, 9'b0}) + 25'(llb) - ((llb != 16'd0) ? 25'd512 : 25'd0);
    end

    always_ff @(posedge i_clk) begin
        r_plan   <= plan;
        r_npg    <= npg;
        r_outlen <= outlen;
        r_base   <= base;
        r_t      <= r_base + 25'(r_plan.pad) + 25'(r_outlen) - 25'd28;
        r_d      <= 25'(r_plan.extra) + 25'(r_plan.drop);
        r_size   <= r_t - r_d;
    end

    assign o_plan = r_plan;
    assign o_new  = '{size: r_size, npg: r_npg, outlen: r_outlen};

endmodule

`default_nettype wire

@@ sv/mzr_front.sv @@
// ----------------------------------------------------------------------------
// MZ header repacker front end
// Accepts file bytes, tracks the file section and builds output jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_last,
    input  wire logic            i_ready,
    input  wire logic            i_sig_enable,
    input  wire mzr_pkg::t_plan  i_plan,
    output logic                 o_stall,
    output mzr_pkg::t_hdr        o_hdr,
    output mzr_pkg::t_job        o_job,
    output logic                 o_load
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_EXTRA,
        PH_RELOC,
        PH_DROP,
        PH_COPY,
        PH_IGNORE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_extra, n_extra;
    logic [15:0] r_relocs, n_relocs;
    logic [23:0] r_word, n_word;
    logic [19:0] r_drop, n_drop;
    logic [3:0]  r_pad, n_pad;
    mzr_pkg::t_hdr r_hdr;

    logic            accept;
    logic            begin_tab, fin, early, clr, ign, sts;
    mzr_pkg::t_status code;
    mzr_pkg::t_body  body;
    logic [3:0]      pad_n;
    logic [31:0]     word;
    logic [31:0]     rw;
    logic [19:0]     a;
    logic [4:0]      blen;
    logic [5:0]      sum;

    assign accept  = i_valid && i_ready;
    assign o_stall = !i_ready;
    assign o_hdr   = r_hdr;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_extra   = r_extra;
        n_relocs  = r_relocs;
        n_word    = r_word;
        n_drop    = r_drop;
        n_pad     = r_pad;
        begin_tab = 1'b0;
        fin       = 1'b0;
        early     = 1'b0;
        clr       = 1'b0;
        ign       = 1'b0;
        sts       = 1'b0;
        code      = mzr_pkg::ST_DATA;
        body      = mzr_pkg::BODY_NONE;
        pad_n     = 4'd0;
        word      = 32'd0;
        rw        = {i_in_byte, r_word};
        a         = {rw[31:16], 4'b0000} + 20'(rw[15:0]);
        unique case (r_phase)
            PH_HDR: begin
                if (r_cnt != 5'(mzr_pkg::HdrLen - 1)) begin
                    n_cnt = r_cnt + 5'd1;
                    if (i_in_last) begin
                        sts  = 1'b1;
                        code = mzr_pkg::ST_SHORT;
                        clr  = 1'b1;
                    end
                end else begin
                    n_cnt = 5'd0;
                    if ({r_hdr[1], r_hdr[0]} != mzr_pkg::MzSig) begin
                        sts  = 1'b1;
                        code = mzr_pkg::ST_NOT_EXE;
                        clr  = 1'b1;
                        ign  = !i_in_last;
                    end else begin
                        body     = mzr_pkg::BODY_HDR;
                        n_extra  = i_plan.extra;
                        n_relocs = i_plan.cnt;
                        n_drop   = i_plan.drop;
                        n_pad    = i_plan.pad;
                        early    = 1'b1;
                        if (i_plan.extra != 16'd0) begin
                            n_phase = PH_EXTRA;
                        end else begin
                            begin_tab = 1'b1;
                        end
                    end
                end
            end
            PH_EXTRA: begin
                n_extra = r_extra - 16'd1;
                early   = 1'b1;
                if (n_extra == 16'd0) begin
                    begin_tab = 1'b1;
                end
            end
            PH_RELOC: begin
                early = 1'b1;
                if (r_cnt[1:0] != 2'd3) begin
                    n_word = {i_in_byte, r_word[23:8]};
                    n_cnt  = r_cnt + 5'd1;
                end else begin
                    body     = mzr_pkg::BODY_REL;
                    word     = {a[19:16], 12'd0, a[15:0]};
                    n_cnt    = 5'd0;
                    n_word   = 24'd0;
                    n_relocs = r_relocs - 16'd1;
                    if (n_relocs == 16'd0) begin
                        fin = 1'b1;
                    end
                end
            end
            PH_DROP: begin
                n_drop = r_drop - 20'd1;
                early  = 1'b1;
                if (n_drop == 20'd0) begin
                    n_phase = PH_COPY;
                end
            end
            PH_COPY: begin
                body = mzr_pkg::BODY_DAT;
                word = {24'd0, i_in_byte};
                clr  = i_in_last;
            end
            PH_IGNORE: begin
                clr = i_in_last;
            end
            default: begin
                clr = 1'b1;
            end
        endcase
        if (begin_tab) begin
            if (n_relocs != 16'd0) begin
                n_phase = PH_RELOC;
                n_cnt   = 5'd0;
                n_word  = 24'd0;
            end else begin
                fin = 1'b1;
            end
        end
        if (fin) begin
            if (!i_in_last) begin
                pad_n = n_pad;
            end
            n_phase = (n_drop != 20'd0) ? PH_DROP : PH_COPY;
        end
        if (early && i_in_last) begin
            sts  = 1'b1;
            code = mzr_pkg::ST_EARLY;
            clr  = 1'b1;
        end
        if (clr) begin
            n_phase  = ign ? PH_IGNORE : PH_HDR;
            n_cnt    = 5'd0;
            n_extra  = 16'd0;
            n_relocs = 16'd0;
            n_word   = 24'd0;
            n_drop   = 20'd0;
            n_pad    = 4'd0;
        end
    end

    always_comb begin
        unique case (body)
            mzr_pkg::BODY_HDR: blen = i_sig_enable ? 5'd30 : 5'd28;
            mzr_pkg::BODY_REL: blen = 5'd4;
            mzr_pkg::BODY_DAT: blen = 5'd1;
            default:           blen = 5'd0;
        endcase
        sum            = 6'(blen) + 6'(pad_n) + 6'(sts);
        o_job.body     = body;
        o_job.blen     = blen;
        o_job.word     = word;
        o_job.dat_last = i_in_last;
        o_job.pad      = pad_n;
        o_job.sts      = sts;
        o_job.code     = code;
        o_job.total    = (sum > 6'd32) ? 6'd32 : sum;
        o_load         = accept && (sum != 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_phase == PH_HDR) begin
            r_hdr[r_cnt] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_cnt    <= 5'd0;
            r_extra  <= 16'd0;
            r_relocs <= 16'd0;
            r_word   <= 24'd0;
            r_drop   <= 20'd0;
            r_pad    <= 4'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_extra  <= n_extra;
            r_relocs <= n_relocs;
            r_word   <= n_word;
            r_drop   <= n_drop;
            r_pad    <= n_pad;
        end
    end

endmodule

`default_nettype wire

@@ sv/mzr_emit.sv @@
// ----------------------------------------------------------------------------
// MZ header repacker emitter
// Serializes one job into output transactions through a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_emit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire mzr_pkg::t_job      i_job,
    input  wire mzr_pkg::t_hdr      i_hdr,
    input  wire mzr_pkg::t_hdr_new  i_new,
    input  wire logic [15:0]        i_sig_value,
    input  wire logic               i_stall,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic [7:0]              o_out_byte,
    output logic                    o_out_last,
    output logic [1:0]              o_status
);

    mzr_pkg::t_job r_job;
    logic [5:0]    r_pos;
    logic          r_active;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [1:0]    r_status;

    logic          adv, done_now;
    logic [5:0]    b1;
    logic [4:0]    idx;
    logic [15:0]   blk;
    logic [7:0]    hb, n_byte;
    logic          n_last;
    logic [1:0]    n_status;

    assign adv      = !r_valid || !i_stall;
    assign done_now = adv && r_active && (r_pos == r_job.total - 6'd1);
    assign o_ready  = !r_active || done_now;

    always_comb begin
        idx = r_pos[4:0];
        blk = i_new.size[24:9] + 16'(i_new.size[8:0] != 9'd0);
        unique case (idx)
            mzr_pkg::IdxLlbLo: hb = i_new.size[7:0];
            mzr_pkg::IdxLlbHi: hb = {7'd0, i_new.size[8]};
            mzr_pkg::IdxBlkLo: hb = blk[7:0];
            mzr_pkg::IdxBlkHi: hb = blk[15:8];
            mzr_pkg::IdxPgLo:  hb = i_new.npg[7:0];
            mzr_pkg::IdxPgHi:  hb = i_new.npg[15:8];
            mzr_pkg::IdxOffLo: hb = {3'd0, i_new.outlen};
            mzr_pkg::IdxOffHi: hb = 8'd0;
            default:           hb = i_hdr[idx];
        endcase
        b1       = 6'(r_job.blen) + 6'(r_job.pad);
        n_byte   = 8'd0;
        n_last   = 1'b0;
        n_status = mzr_pkg::ST_DATA;
        if (r_pos < 6'(r_job.blen)) begin
            unique case (r_job.body)
                mzr_pkg::BODY_HDR: begin
                    if (r_pos < 6'(mzr_pkg::HdrLen)) begin
                        n_byte = hb;
                    end else begin
                        n_byte = r_pos[0] ? i_sig_value[15:8] : i_sig_value[7:0];
                    end
                end
                mzr_pkg::BODY_REL: begin
                    unique case (r_pos[1:0])
                        2'd0:    n_byte = r_job.word[7:0];
                        2'd1:    n_byte = r_job.word[15:8];
                        2'd2:    n_byte = r_job.word[23:16];
                        default: n_byte = r_job.word[31:24];
                    endcase
                end
                mzr_pkg::BODY_DAT: begin
                    n_byte = r_job.word[7:0];
                    n_last = r_job.dat_last;
                end
                default: n_byte = 8'd0;
            endcase
        end else if (r_pos >= b1) begin
            n_last   = 1'b1;
            n_status = r_job.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_pos    <= 6'd0;
        end else begin
            if (adv) begin
                r_valid <= r_active;
                if (r_active) begin
                    r_byte   <= n_byte;
                    r_last   <= n_last;
                    r_status <= n_status;
                    r_pos    <= r_pos + 6'd1;
                    if (done_now) begin
                        r_active <= 1'b0;
                    end
                end
            end
            if (i_load) begin
                r_job    <= i_job;
                r_pos    <= 6'd0;
                r_active <= 1'b1;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;
    assign o_status   = r_status;

endmodule

`default_nettype wire

@@ sv/mz_header_repacker.sv @@
// A byte's first result is registered in the job register and then in the result register.
// Throughput: while the receiver does not stall, one byte per cycle in the load image,
// relocation bytes and skipped regions; the header byte and each fourth relocation byte hold
// input until their burst (up to 32 results) has drained through the result register, one per cycle.
// Reset: synchronous active low; clears the file state, config registers and output valid.
// The header store needs no clearing pass.
// ----------------------------------------------------------------------------
// MZ header repacker
// Streams a DOS MZ executable and rewrites its header and relocation table.
// ----------------------------------------------------------------------------
`default_nettype none

module mz_header_repacker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [1:0]       o_status
);

    localparam logic CfgSigEnable = 1'b0;
    localparam logic CfgSigValue  = 1'b1;

    logic        r_sig_enable;
    logic [15:0] r_sig_value;

    mzr_pkg::t_hdr     hdr;
    mzr_pkg::t_plan    plan;
    mzr_pkg::t_hdr_new hnew;
    mzr_pkg::t_job     job;
    logic              load, ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_enable <= 1'b0;
            r_sig_value  <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgSigEnable: r_sig_enable <= i_cfg_data[0];
                CfgSigValue:  r_sig_value  <= i_cfg_data;
                default:      r_sig_value  <= r_sig_value;
            endcase
        end
    end

    mzr_hdr_calc u_calc (
        .i_clk        (i_clk),
        .i_hdr        (hdr),
        .i_sig_enable (r_sig_enable),
        .o_plan       (plan),
        .o_new        (hnew)
    );

    mzr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_ready      (ready),
        .i_sig_enable (r_sig_enable),
        .i_plan       (plan),
        .o_stall      (o_stall),
        .o_hdr        (hdr),
        .o_job        (job),
        .o_load       (load)
    );

    mzr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_hdr       (hdr),
        .i_new       (hnew),
        .i_sig_value (r_sig_value),
        .i_stall     (i_stall),
        .o_ready     (ready),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

@@ dv/mzr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MZ repacker result checker
// Watches both channels and the register port, predicts the rewritten file
// bytes and status codes, and compares each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_stall,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_out_last,
    input  wire logic [1:0]  i_status,
    output int               o_errors,
    output int               o_pending
);

    typedef enum logic [2:0] {
        PH_HDR, PH_EXTRA, PH_RELOC, PH_DROP, PH_COPY, PH_IGNORE
    } t_phase;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        mzr_pkg::t_status code;
    } t_result;

    t_result     expected_q[$];
    logic [7:0]  hdr [mzr_pkg::HdrLen];
    t_phase      phase;
    logic [15:0] cnt_in_phase;
    logic [15:0] extra_left;
    logic [15:0] relocs_left;
    logic [31:0] reloc_acc;
    logic [19:0] drop_left;
    logic [3:0]  pad_len;
    logic        sig_en;
    logic [15:0] sig_word;
    int          errors;
    int          pending_n = 0;

    assign o_errors  = errors;
    assign o_pending = pending_n;

    function automatic logic [15:0] hdr16(int i);
        return {hdr[i + 1], hdr[i]};
    endfunction

    task automatic push(logic [7:0] d, logic l, mzr_pkg::t_status c);
        t_result r;
        r.data = d;
        r.last = l;
        r.code = c;
        expected_q.push_back(r);
    endtask

    task automatic clear_file();
        phase = PH_HDR;
        cnt_in_phase = 0;
        extra_left = 0;
        relocs_left = 0;
        reloc_acc = 0;
        drop_left = 0;
        pad_len = 0;
    endtask

    task automatic close_table(logic last);
        if (!last) begin
            for (int i = 0; i < pad_len; i++) push(8'h00, 1'b0, mzr_pkg::ST_DATA);
        end
        phase = (drop_left != 0) ? PH_DROP : PH_COPY;
    endtask

    task automatic open_table(logic last);
        if (relocs_left != 0) begin
            phase = PH_RELOC;
            cnt_in_phase = 0;
            reloc_acc = 0;
        end else begin
            close_table(last);
        end
    endtask

    task automatic repack_header(logic last);
        logic [31:0] llb, blk, cnt, pg, off, outlen, rlen, extra, oldend, drop, npg, pad, size;
        logic [31:0] blocks;
        llb = hdr16(2);
        blk = hdr16(4);
        cnt = hdr16(6);
        pg = hdr16(8);
        off = hdr16(24);
        outlen = mzr_pkg::HdrLen + (sig_en ? 2 : 0);
        rlen = cnt * 4;
        extra = (off > mzr_pkg::HdrLen) ? off - mzr_pkg::HdrLen : 0;
        oldend = off + rlen;
        drop = ((pg << 4) > oldend) ? (pg << 4) - oldend : 0;
        npg = (outlen + rlen + 15) >> 4;
        pad = (npg << 4) - (outlen + rlen);
        size = (blk << 9) + llb;
        if (llb != 0) size = size - 512;
        size = size - extra - drop + pad + (outlen - mzr_pkg::HdrLen);
        blocks = (size + 32'h1FF) >> 9;
        hdr[2] = size[7:0];
        hdr[3] = {7'd0, size[8]};
        hdr[4] = blocks[7:0];
        hdr[5] = blocks[15:8];
        hdr[8] = npg[7:0];
        hdr[9] = npg[15:8];
        hdr[24] = outlen[7:0];
        hdr[25] = 8'h00;
        for (int i = 0; i < mzr_pkg::HdrLen; i++) push(hdr[i], 1'b0, mzr_pkg::ST_DATA);
        if (sig_en) begin
            push(sig_word[7:0], 1'b0, mzr_pkg::ST_DATA);
            push(sig_word[15:8], 1'b0, mzr_pkg::ST_DATA);
        end
        extra_left = extra[15:0];
        relocs_left = cnt[15:0];
        drop_left = drop[19:0];
        pad_len = pad[3:0];
        if (extra_left != 0) phase = PH_EXTRA;
        else open_table(last);
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        logic [31:0] w, a;
        case (phase)
            PH_HDR: begin
                hdr[cnt_in_phase] = b;
                cnt_in_phase++;
                if (cnt_in_phase < mzr_pkg::HdrLen) begin
                    if (last) begin
                        push(8'h00, 1'b1, mzr_pkg::ST_SHORT);
                        clear_file();
                    end
                    return;
                end
                cnt_in_phase = 0;
                if (hdr16(0) != mzr_pkg::MzSig) begin
                    push(8'h00, 1'b1, mzr_pkg::ST_NOT_EXE);
                    clear_file();
                    if (!last) phase = PH_IGNORE;
                    return;
                end
                repack_header(last);
            end
            PH_EXTRA: begin
                extra_left--;
                if (extra_left == 0) open_table(last);
            end
            PH_RELOC: begin
                reloc_acc |= 32'(b) << (8 * cnt_in_phase[1:0]);
                cnt_in_phase++;
                if (cnt_in_phase >= 4) begin
                    w = reloc_acc;
                    a = ((w >> 12) & 32'hFFFF0) + (w & 32'hFFFF);
                    w = ((a & 32'hF0000) << 12) | (a & 32'hFFFF);
                    push(w[7:0], 1'b0, mzr_pkg::ST_DATA);
                    push(w[15:8], 1'b0, mzr_pkg::ST_DATA);
                    push(w[23:16], 1'b0, mzr_pkg::ST_DATA);
                    push(w[31:24], 1'b0, mzr_pkg::ST_DATA);
                    cnt_in_phase = 0;
                    reloc_acc = 0;
                    relocs_left--;
                    if (relocs_left == 0) close_table(last);
                end
            end
            PH_DROP: begin
                drop_left--;
                if (drop_left == 0) phase = PH_COPY;
            end
            PH_COPY: begin
                push(b, last, mzr_pkg::ST_DATA);
                if (last) clear_file();
                return;
            end
            default: begin
                if (last) clear_file();
                return;
            end
        endcase
        if (last) begin
            push(8'h00, 1'b1, mzr_pkg::ST_EARLY);
            clear_file();
        end
    endtask

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            clear_file();
            sig_en <= 1'b0;
            sig_word <= 16'h0000;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) sig_word <= i_cfg_data;
                else sig_en <= i_cfg_data[0];
            end
            if (i_valid && !i_stall_in) predict_byte(i_in_byte, i_in_last);
            if (i_out_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transaction", i_out_byte, 8'h00);
                end else begin
                    r = expected_q.pop_front();
                    if (i_out_byte !== r.data) report("out_byte", i_out_byte, r.data);
                    if (i_out_last !== r.last) report("out_last", 8'(i_out_last), 8'(r.last));
                    if (i_status !== r.code) report("status", 8'(i_status), 8'(r.code));
                end
            end
        end
        pending_n = expected_q.size();
    end

    initial errors = 0;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MZ header repacker testbench
// Streams directed and random MZ files under random gaps and back-pressure
// across several signature settings; a checker module judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam logic IdxSigEn  = 1'b0;
    localparam logic IdxSigVal = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = IdxSigEn;
    logic [15:0] cfg_data = 16'h0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  out_status;
    int          errors;
    int          pending;
    logic        hold_off = 1'b0;
    int          sent = 0;
    logic [7:0]  file_q[$];

    always #4 clk = ~clk;

    mz_header_repacker u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_in_byte(in_byte), .i_in_last(in_last),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_byte(out_byte), .o_out_last(out_last), .o_status(out_status)
    );

    mzr_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_in_byte(in_byte), .i_in_last(in_last),
        .i_out_valid(out_valid), .i_stall(out_stall),
        .i_out_byte(out_byte), .i_out_last(out_last), .i_status(out_status),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 8);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(3);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else if ($urandom_range(3) == 0) out_stall <= 1'b1;
        else out_stall <= 1'b0;
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // send the queued file; the valid stays high across back-to-back bytes
    task automatic send_file(logic quiet);
        int n;
        int g;
        n = file_q.size();
        for (int i = 0; i < n; i++) begin
            in_valid <= 1'b1;
            in_byte <= file_q[i];
            in_last <= (i == n - 1);
            @(posedge clk);
            while (in_stall) @(posedge clk);
            sent++;
            @(negedge clk);
            g = quiet ? 0 : gap_len();
            if (i == n - 1 && g == 0) g = 1;
            if (g != 0) begin
                in_valid <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    endtask

    task automatic put16(int i, logic [15:0] v);
        file_q[i] = v[7:0];
        file_q[i + 1] = v[15:8];
    endtask

    // build an MZ file: header, extra bytes, relocations, drop area, image
    task automatic build_file(int cnt, int extra, int drop, int image, logic good_sig);
        int off, pg;
        file_q.delete();
        off = 28 + extra;
        pg = (off + 4 * cnt + drop + 15) / 16;
        for (int i = 0; i < 28; i++) file_q.push_back(8'($urandom));
        if (good_sig) put16(0, mzr_pkg::MzSig);
        put16(6, 16'(cnt));
        put16(8, 16'(pg));
        put16(24, 16'(off));
        if ($urandom_range(5) == 0) put16(24, 16'($urandom_range(27)));
        for (int i = 0; i < pg * 16 - 28 + image; i++) file_q.push_back(8'($urandom));
    endtask

    task automatic idle_wait();
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        write_reg(IdxSigEn, 16'h0001);
        write_reg(IdxSigVal, 16'h0000);

        // directed: short header, bad signature, extremes, early end
        file_q.delete();
        for (int i = 0; i < 5; i++) file_q.push_back(8'hFF);
        send_file(1'b0);
        file_q = '{8'h00, 8'hFF};
        send_file(1'b0);
        build_file(2, 0, 0, 3, 1'b0);
        send_file(1'b0);
        build_file(1, 4, 3, 2, 1'b1);
        put16(28 + 4, 16'hFFFF);
        put16(28 + 6, 16'hFFFF);
        send_file(1'b0);
        build_file(1, 0, 0, 0, 1'b1);
        file_q = file_q[0:29];
        send_file(1'b0);
        idle_wait();

        write_reg(IdxSigEn, 16'h0000);
        write_reg(IdxSigVal, 16'hFFFF);
        build_file(0, 0, 0, 1, 1'b1);
        put16(2, 16'h0000);
        send_file(1'b0);

        // long receiver hold-off while input keeps coming
        build_file(6, 2, 1, 20, 1'b1);
        fork
            send_file(1'b1);
            begin
                hold_off <= 1'b1;
                repeat (120) @(negedge clk);
                hold_off <= 1'b0;
            end
        join
        idle_wait();

        while (sent < 310) begin
            if ($urandom_range(3) == 0) begin
                idle_wait();
                write_reg(IdxSigEn, 16'($urandom_range(1)));
                write_reg(IdxSigVal, 16'($urandom));
            end
            build_file($urandom_range(4), $urandom_range(6), $urandom_range(5),
                       $urandom_range(8), $urandom_range(9) != 0);
            if ($urandom_range(6) == 0) file_q = file_q[0:$urandom_range(file_q.size() - 1)];
            send_file(1'b0);
        end
        idle_wait();
        repeat (40) @(negedge clk);
        if (errors == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/mzr_pkg.sv
sv/mzr_hdr_calc.sv
sv/mzr_front.sv
sv/mzr_emit.sv
sv/mz_header_repacker.sv
dv/mzr_checker.sv
dv/tb.sv
